### rtl/ils_pkg.sv
// Shared types, constants and field layouts of the indexed list store.
package ils_pkg;

	localparam int MAX_DEPTH = 64;
	localparam int DATA_W    = 32;
	localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
	localparam int POS_W     = $clog2(MAX_DEPTH);
	localparam int MODE_W    = 3;
	localparam int STAT_W    = 2;
	localparam int GRP_SIZE  = 8;
	localparam int NGRP      = (MAX_DEPTH + GRP_SIZE - 1) / GRP_SIZE;

	localparam int IN_W  = ((MODE_W + CNT_W + DATA_W + 7) / 8) * 8;
	localparam int OUT_W = ((DATA_W + STAT_W + CNT_W + CNT_W + 7) / 8) * 8;

	localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_EDIT   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BADIDX = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(5);
	localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(MAX_DEPTH);

	typedef enum logic [2:0] {
		OP_NONE,
		OP_APPEND,
		OP_INSERT,
		OP_DELETE,
		OP_EDIT
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [CNT_W-1:0]  idx;
		logic [CNT_W-1:0]  cnt;
		logic [DATA_W-1:0] data;
	} cell_ctrl_t;

	typedef enum logic {
		ST_IDLE,
		ST_GATHER
	} state_t;

endpackage

### rtl/ils_cell.sv
// One storage cell of the list: holds one entry and shifts it with its neighbors.
module ils_cell (
	input  logic                         clk,
	input  ils_pkg::cell_ctrl_t          ctrl,
	input  logic [ils_pkg::POS_W-1:0]    pos,
	input  logic [ils_pkg::DATA_W-1:0]   left_data,
	input  logic [ils_pkg::DATA_W-1:0]   right_data,
	output logic [ils_pkg::DATA_W-1:0]   entry,
	output logic [ils_pkg::DATA_W-1:0]   sel_data
);

	logic [ils_pkg::DATA_W-1:0] entry_q;
	logic [ils_pkg::DATA_W-1:0] entry_d;
	logic [ils_pkg::CNT_W-1:0]  pos_x;
	logic [ils_pkg::CNT_W-1:0]  pos_n;

	assign pos_x = ils_pkg::CNT_W'(pos);
	assign pos_n = pos_x + ils_pkg::CNT_W'(1);

	always_comb begin
		entry_d = entry_q;
		unique case (ctrl.op)
			ils_pkg::OP_APPEND: begin
				if (pos_x == ctrl.cnt) entry_d = ctrl.data;
			end
			ils_pkg::OP_INSERT: begin
				if (pos_x == ctrl.idx) entry_d = ctrl.data;
				else if (pos_x > ctrl.idx && pos_x <= ctrl.cnt) entry_d = left_data;
			end
			ils_pkg::OP_DELETE: begin
				if (pos_x >= ctrl.idx && pos_n < ctrl.cnt) entry_d = right_data;
			end
			ils_pkg::OP_EDIT: begin
				if (pos_x == ctrl.idx) entry_d = ctrl.data;
			end
			default: entry_d = entry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry    = entry_q;
	assign sel_data = (pos_x == ctrl.idx) ? entry_q : '0;

endmodule

### rtl/indexed_list_store.sv
// Top level of the indexed list store: control, cell row, read gather and output register.
//
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata: mode, index, data
// m_axis    out  tvalid/tready          tdata: read_data, status, entry_count, logical_capacity
// cfg       in   cfg_valid/cfg_ready    cfg_data: initial_capacity
//
// Each operation updates the cell row and registers the read groups in the accept
// cycle; the result is then loaded into the output register from the gather stage
// once that register is free. A read goes through a two-level registered OR tree over the cells.
// Reset clears the count and loads capacity 5; entries are undefined until written.
// A result waiting in the output register does not block the next accept; a second
// result waits in the gather stage until the output register frees up.
module indexed_list_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// Fields from bit 0: mode[2:0], index[9:3], data[41:10], zero fill.
	input  logic [ils_pkg::IN_W-1:0]     s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// Fields from bit 0: read_data[31:0], status[33:32], entry_count[40:34],
	// logical_capacity[47:41].
	output logic [ils_pkg::OUT_W-1:0]    m_axis_tdata,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ils_pkg::CNT_W-1:0]    cfg_data
);

	localparam int IDX_LO  = ils_pkg::MODE_W;
	localparam int DATA_LO = ils_pkg::MODE_W + ils_pkg::CNT_W;

	ils_pkg::state_t state_q, state_d;

	logic [ils_pkg::CNT_W-1:0]  count_q, count_d;
	logic [ils_pkg::CNT_W-1:0]  cap_q, cap_d;
	logic [ils_pkg::STAT_W-1:0] status_s1, status_d;
	logic                       is_read_s1;
	logic [ils_pkg::DATA_W-1:0] grp_s1 [ils_pkg::NGRP];
	logic [ils_pkg::DATA_W-1:0] grp_d  [ils_pkg::NGRP];
	logic                       out_valid_q;
	logic [ils_pkg::OUT_W-1:0]  out_q;

	logic                       in_accept;
	logic                       load_out;
	logic [ils_pkg::MODE_W-1:0] in_mode;
	logic [ils_pkg::CNT_W-1:0]  in_idx;
	logic [ils_pkg::DATA_W-1:0] in_data;
	logic [ils_pkg::CNT_W:0]    cap_dbl;
	logic [ils_pkg::CNT_W-1:0]  cap_grow;
	logic [ils_pkg::CNT_W-1:0]  cnt_dec;
	logic [ils_pkg::CNT_W-1:0]  cap_half;
	logic [ils_pkg::CNT_W-1:0]  cfg_cap;
	logic [ils_pkg::DATA_W-1:0] rd_or;
	logic [ils_pkg::DATA_W-1:0] rd_word;
	ils_pkg::cell_ctrl_t        ctrl;

	logic [ils_pkg::DATA_W-1:0] cell_entry [ils_pkg::MAX_DEPTH];
	logic [ils_pkg::DATA_W-1:0] cell_sel   [ils_pkg::MAX_DEPTH];

	assign in_mode = s_axis_tdata[IDX_LO-1:0];
	assign in_idx  = s_axis_tdata[DATA_LO-1:IDX_LO];
	assign in_data = s_axis_tdata[DATA_LO+ils_pkg::DATA_W-1:DATA_LO];

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	assign cap_dbl  = {cap_q, 1'b0};
	assign cap_grow = (count_q < cap_q) ? cap_q :
	                  (cap_dbl > (ils_pkg::CNT_W+1)'(ils_pkg::MAX_DEPTH)) ? ils_pkg::CAP_MAX :
	                  cap_dbl[ils_pkg::CNT_W-1:0];
	assign cnt_dec  = count_q - ils_pkg::CNT_W'(1);
	assign cap_half = cap_q >> 1;

	assign cfg_cap = (cfg_data == '0) ? ils_pkg::CNT_W'(1) :
	                 (cfg_data > ils_pkg::CAP_MAX) ? ils_pkg::CAP_MAX : cfg_data;

	always_comb begin
		ctrl.op   = ils_pkg::OP_NONE;
		ctrl.idx  = in_idx;
		ctrl.cnt  = count_q;
		ctrl.data = in_data;
		count_d   = count_q;
		cap_d     = cap_q;
		status_d  = ils_pkg::STAT_OK;
		unique case (in_mode)
			ils_pkg::MODE_APPEND: begin
				if (count_q >= ils_pkg::CAP_MAX) begin
					status_d = ils_pkg::STAT_FULL;
				end else begin
					ctrl.op = ils_pkg::OP_APPEND;
					cap_d   = cap_grow;
					count_d = count_q + ils_pkg::CNT_W'(1);
				end
			end
			ils_pkg::MODE_INSERT: begin
				if (in_idx > count_q) begin
					status_d = ils_pkg::STAT_BADIDX;
				end else if (count_q >= ils_pkg::CAP_MAX) begin
					status_d = ils_pkg::STAT_FULL;
				end else begin
					ctrl.op = ils_pkg::OP_INSERT;
					cap_d   = cap_grow;
					count_d = count_q + ils_pkg::CNT_W'(1);
				end
			end
			ils_pkg::MODE_DELETE: begin
				if (in_idx >= count_q) begin
					status_d = ils_pkg::STAT_BADIDX;
				end else begin
					ctrl.op = ils_pkg::OP_DELETE;
					count_d = cnt_dec;
					if (cap_q > ils_pkg::CNT_W'(1) && cnt_dec <= cap_half) cap_d = cap_half;
				end
			end
			ils_pkg::MODE_EDIT: begin
				if (in_idx >= count_q) status_d = ils_pkg::STAT_BADIDX;
				else ctrl.op = ils_pkg::OP_EDIT;
			end
			ils_pkg::MODE_READ: begin
				if (in_idx >= count_q) status_d = ils_pkg::STAT_BADIDX;
			end
			default: status_d = ils_pkg::STAT_OK;
		endcase
		if (!in_accept) ctrl.op = ils_pkg::OP_NONE;
	end

	for (genvar i = 0; i < ils_pkg::MAX_DEPTH; i++) begin : g_cell
		logic [ils_pkg::DATA_W-1:0] left_w;
		logic [ils_pkg::DATA_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = in_data;
		end else begin : g_mid_l
			assign left_w = cell_entry[i-1];
		end
		if (i == ils_pkg::MAX_DEPTH - 1) begin : g_last
			assign right_w = cell_entry[i];
		end else begin : g_mid_r
			assign right_w = cell_entry[i+1];
		end
		ils_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.pos        (ils_pkg::POS_W'(i)),
			.left_data  (left_w),
			.right_data (right_w),
			.entry      (cell_entry[i]),
			.sel_data   (cell_sel[i])
		);
	end

	always_comb begin
		for (int g = 0; g < ils_pkg::NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < ils_pkg::GRP_SIZE; k++) begin
				if (g * ils_pkg::GRP_SIZE + k < ils_pkg::MAX_DEPTH) begin
					grp_d[g] = grp_d[g] | cell_sel[g * ils_pkg::GRP_SIZE + k];
				end
			end
		end
	end

	always_comb begin
		rd_or = '0;
		for (int g = 0; g < ils_pkg::NGRP; g++) begin
			rd_or = rd_or | grp_s1[g];
		end
		rd_word = (is_read_s1 && status_s1 == ils_pkg::STAT_OK) ? rd_or : '1;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ils_pkg::ST_IDLE:   if (in_accept) state_d = ils_pkg::ST_GATHER;
			ils_pkg::ST_GATHER: if (load_out) state_d = ils_pkg::ST_IDLE;
			default:            state_d = ils_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == ils_pkg::ST_IDLE);
		load_out      = (state_q == ils_pkg::ST_GATHER) && (!out_valid_q || m_axis_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ils_pkg::ST_IDLE;
			count_q     <= '0;
			cap_q       <= ils_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				count_q <= '0;
				cap_q   <= cfg_cap;
			end else if (in_accept) begin
				count_q <= count_d;
				cap_q   <= cap_d;
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			status_s1  <= status_d;
			is_read_s1 <= (in_mode == ils_pkg::MODE_READ);
			for (int g = 0; g < ils_pkg::NGRP; g++) grp_s1[g] <= grp_d[g];
		end
		if (load_out) begin
			out_q <= ils_pkg::OUT_W'({cap_q, count_q, status_s1, rd_word});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	a_count_range : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ils_pkg::CAP_MAX)
		else $error("entry count above the store depth");

	a_cap_range : assert property (@(posedge clk) disable iff (!arst_n)
		cap_q >= ils_pkg::CNT_W'(1) && cap_q <= ils_pkg::CAP_MAX)
		else $error("logical capacity out of range");

	a_accept_gather : assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == ils_pkg::ST_GATHER)
		else $error("accepted transaction did not enter the gather stage");

	a_load_valid : assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("loaded result not presented on the output");

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the indexed list store: directed table, then random phases.
`timescale 1ns / 1ps

module tb;

	localparam logic [ils_pkg::MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [ils_pkg::MODE_W-1:0] MODE_UNUSED_MID = 3'd6;
	localparam logic [ils_pkg::MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
	localparam logic [ils_pkg::DATA_W-1:0] NO_DATA = '1;

	typedef struct packed {
		logic [ils_pkg::DATA_W-1:0] read_data;
		logic [ils_pkg::STAT_W-1:0] status;
		logic [ils_pkg::CNT_W-1:0]  entry_count;
		logic [ils_pkg::CNT_W-1:0]  logical_capacity;
	} list_result_t;

	typedef struct {
		logic [ils_pkg::MODE_W-1:0] mode;
		logic [ils_pkg::CNT_W-1:0]  index;
		logic [ils_pkg::DATA_W-1:0] data;
		bit                         typed;
		list_result_t               want;
	} op_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       s_axis_tvalid;
	logic                       s_axis_tready;
	// Fields from bit 0: mode, index, data, zero fill.
	logic [ils_pkg::IN_W-1:0]   s_axis_tdata;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready;
	// Fields from bit 0: read_data, status, entry_count, logical_capacity.
	logic [ils_pkg::OUT_W-1:0]  m_axis_tdata;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [ils_pkg::CNT_W-1:0]  cfg_data;

	logic [ils_pkg::DATA_W-1:0] entry_mem [0:ils_pkg::MAX_DEPTH-1];
	int                         list_len;
	int                         list_cap;
	list_result_t               pending_results [$];
	op_row_t                    op_table [$];
	int                         err_count;
	bit                         idle_on;

	indexed_list_store dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void load_capacity(input logic [ils_pkg::CNT_W-1:0] v);
		list_len = 0;
		if (v == 0) begin
			list_cap = 1;
		end else if (int'(v) > ils_pkg::MAX_DEPTH) begin
			list_cap = ils_pkg::MAX_DEPTH;
		end else begin
			list_cap = int'(v);
		end
	endfunction

	function automatic void grow_capacity();
		if (list_len >= list_cap) begin
			list_cap = (list_cap * 2 > ils_pkg::MAX_DEPTH) ? ils_pkg::MAX_DEPTH : list_cap * 2;
		end
	endfunction

	function automatic list_result_t list_model_step(input logic [ils_pkg::MODE_W-1:0] m,
			input logic [ils_pkg::CNT_W-1:0] ix, input logic [ils_pkg::DATA_W-1:0] d);
		list_result_t r;
		int           pos;
		int           i;
		pos = int'(ix);
		r.read_data = NO_DATA;
		r.status = ils_pkg::STAT_OK;
		case (m)
			ils_pkg::MODE_APPEND: begin
				if (list_len >= ils_pkg::MAX_DEPTH) begin
					r.status = ils_pkg::STAT_FULL;
				end else begin
					grow_capacity();
					entry_mem[list_len] = d;
					list_len++;
				end
			end
			ils_pkg::MODE_INSERT: begin
				if (pos > list_len) begin
					r.status = ils_pkg::STAT_BADIDX;
				end else if (list_len >= ils_pkg::MAX_DEPTH) begin
					r.status = ils_pkg::STAT_FULL;
				end else begin
					grow_capacity();
					for (i = list_len; i > pos; i--) entry_mem[i] = entry_mem[i-1];
					entry_mem[pos] = d;
					list_len++;
				end
			end
			ils_pkg::MODE_DELETE: begin
				if (pos >= list_len) begin
					r.status = ils_pkg::STAT_BADIDX;
				end else begin
					for (i = pos; i + 1 < list_len; i++) entry_mem[i] = entry_mem[i+1];
					list_len--;
					if (list_cap > 1 && list_len <= list_cap / 2) list_cap = list_cap / 2;
				end
			end
			ils_pkg::MODE_EDIT: begin
				if (pos >= list_len) r.status = ils_pkg::STAT_BADIDX;
				else entry_mem[pos] = d;
			end
			ils_pkg::MODE_READ: begin
				if (pos >= list_len) r.status = ils_pkg::STAT_BADIDX;
				else r.read_data = entry_mem[pos];
			end
			default: begin
			end
		endcase
		r.entry_count = ils_pkg::CNT_W'(list_len);
		r.logical_capacity = ils_pkg::CNT_W'(list_cap);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [ils_pkg::DATA_W-1:0] got,
			input logic [ils_pkg::DATA_W-1:0] want);
		err_count++;
		$display("tb: mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
	endtask

	always @(negedge clk) begin
		m_axis_tready <= idle_on ? ($urandom_range(0, 99) >= 18) : 1'b1;
	end

	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[$bits(list_result_t)-1:0];
			got.read_data = m_axis_tdata[31:0];
			got.status = m_axis_tdata[33:32];
			got.entry_count = m_axis_tdata[40:34];
			got.logical_capacity = m_axis_tdata[47:41];
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, read_data", got.read_data, 0);
			end else begin
				want = pending_results.pop_front();
				if (got.read_data !== want.read_data)
					report_mismatch("read_data", got.read_data, want.read_data);
				if (got.status !== want.status)
					report_mismatch("status", got.status, want.status);
				if (got.entry_count !== want.entry_count)
					report_mismatch("entry_count", got.entry_count, want.entry_count);
				if (got.logical_capacity !== want.logical_capacity)
					report_mismatch("logical_capacity", got.logical_capacity,
						want.logical_capacity);
			end
		end
	end

	task automatic send_op(input logic [ils_pkg::MODE_W-1:0] m,
			input logic [ils_pkg::CNT_W-1:0] ix, input logic [ils_pkg::DATA_W-1:0] d,
			input bit typed, input list_result_t want);
		list_result_t pred;
		if (idle_on && $urandom_range(0, 99) < 18) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = ils_pkg::IN_W'({d, ix, m});
		do @(posedge clk); while (!s_axis_tready);
		pred = list_model_step(m, ix, d);
		pending_results.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [ils_pkg::CNT_W-1:0] v);
		wait_drained();
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		load_capacity(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic random_op(input bit grow);
		int                         r;
		logic [ils_pkg::MODE_W-1:0] m;
		logic [ils_pkg::CNT_W-1:0]  ix;
		r = $urandom_range(0, 99);
		if (r < 3) m = ils_pkg::MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
		else if (r < (grow ? 45 : 15)) m = ils_pkg::MODE_APPEND;
		else if (r < (grow ? 75 : 30)) m = ils_pkg::MODE_INSERT;
		else if (r < (grow ? 85 : 65)) m = ils_pkg::MODE_DELETE;
		else if (r < (grow ? 92 : 80)) m = ils_pkg::MODE_EDIT;
		else m = ils_pkg::MODE_READ;
		if (m == ils_pkg::MODE_APPEND || $urandom_range(0, 99) < 10) begin
			ix = ils_pkg::CNT_W'($urandom_range(0, 127));
		end else if (m == ils_pkg::MODE_INSERT) begin
			ix = ils_pkg::CNT_W'($urandom_range(0, list_len));
		end else begin
			ix = (list_len == 0) ? '0 : ils_pkg::CNT_W'($urandom_range(0, list_len - 1));
		end
		send_op(m, ix, $urandom, 1'b0, '0);
	endtask

	task automatic fill_and_probe();
		while (list_len < ils_pkg::MAX_DEPTH) begin
			if ($urandom_range(0, 1)) begin
				send_op(ils_pkg::MODE_APPEND, '0, $urandom, 1'b0, '0);
			end else begin
				send_op(ils_pkg::MODE_INSERT, ils_pkg::CNT_W'($urandom_range(0, list_len)),
					$urandom, 1'b0, '0);
			end
		end
		send_op(ils_pkg::MODE_APPEND, '0, $urandom, 1'b0, '0);
		send_op(ils_pkg::MODE_INSERT, '0, $urandom, 1'b0, '0);
		send_op(ils_pkg::MODE_INSERT, ils_pkg::CNT_W'(ils_pkg::MAX_DEPTH), $urandom, 1'b0, '0);
		send_op(ils_pkg::MODE_INSERT, ils_pkg::CNT_W'(ils_pkg::MAX_DEPTH + 1), $urandom,
			1'b0, '0);
		send_op(ils_pkg::MODE_EDIT, ils_pkg::CNT_W'(ils_pkg::MAX_DEPTH - 1), $urandom,
			1'b0, '0);
		send_op(ils_pkg::MODE_READ, ils_pkg::CNT_W'(ils_pkg::MAX_DEPTH - 1), '0, 1'b0, '0);
		send_op(ils_pkg::MODE_READ, ils_pkg::CNT_W'(ils_pkg::MAX_DEPTH), '0, 1'b0, '0);
		while (list_len > 0) begin
			if ($urandom_range(0, 3) == 0) begin
				random_op(1'b0);
			end else begin
				send_op(ils_pkg::MODE_DELETE, ils_pkg::CNT_W'($urandom_range(0, list_len - 1)),
					'0, 1'b0, '0);
			end
		end
	endtask

	task automatic add_row(input logic [ils_pkg::MODE_W-1:0] m,
			input logic [ils_pkg::CNT_W-1:0] ix, input logic [ils_pkg::DATA_W-1:0] d,
			input bit typed, input logic [ils_pkg::DATA_W-1:0] rd,
			input logic [ils_pkg::STAT_W-1:0] st, input int cnt, input int cap);
		op_row_t row;
		row.mode = m;
		row.index = ix;
		row.data = d;
		row.typed = typed;
		row.want.read_data = rd;
		row.want.status = st;
		row.want.entry_count = ils_pkg::CNT_W'(cnt);
		row.want.logical_capacity = ils_pkg::CNT_W'(cap);
		op_table.push_back(row);
	endtask

	initial begin
		logic [ils_pkg::CNT_W-1:0] cap_settings [9];
		bit                        grow;
		int                        run;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		err_count = 0;
		idle_on = 1'b1;
		for (int i = 0; i < ils_pkg::MAX_DEPTH; i++) entry_mem[i] = '0;
		load_capacity(ils_pkg::CAP_RESET);
		cap_settings = '{7'd1, 7'd127, 7'd0, 7'd64, 7'd2, 7'd3, 7'd17, 7'd40,
			ils_pkg::CNT_W'($urandom_range(1, 64))};

		add_row(ils_pkg::MODE_READ, 7'd0, 32'h0, 1'b1, NO_DATA, ils_pkg::STAT_BADIDX, 0, 5);
		add_row(ils_pkg::MODE_DELETE, 7'd0, 32'h0, 1'b1, NO_DATA, ils_pkg::STAT_BADIDX, 0, 5);
		add_row(ils_pkg::MODE_EDIT, 7'd0, 32'h1, 1'b1, NO_DATA, ils_pkg::STAT_BADIDX, 0, 5);
		add_row(ils_pkg::MODE_INSERT, 7'd1, 32'h2, 1'b1, NO_DATA, ils_pkg::STAT_BADIDX, 0, 5);
		add_row(ils_pkg::MODE_INSERT, 7'd127, 32'h3, 1'b1, NO_DATA, ils_pkg::STAT_BADIDX,
			0, 5);
		add_row(MODE_UNUSED_LO, 7'd0, 32'h4, 1'b1, NO_DATA, ils_pkg::STAT_OK, 0, 5);
		add_row(MODE_UNUSED_HI, 7'd127, 32'hFFFFFFFF, 1'b1, NO_DATA, ils_pkg::STAT_OK, 0, 5);
		add_row(ils_pkg::MODE_APPEND, 7'd0, 32'h7FFFFFFF, 1'b1, NO_DATA, ils_pkg::STAT_OK,
			1, 5);
		add_row(ils_pkg::MODE_APPEND, 7'd127, 32'h80000000, 1'b1, NO_DATA, ils_pkg::STAT_OK,
			2, 5);
		add_row(ils_pkg::MODE_INSERT, 7'd0, 32'hFFFFFFFF, 1'b0, '0, '0, 0, 0);
		add_row(ils_pkg::MODE_INSERT, 7'd3, 32'h0, 1'b0, '0, '0, 0, 0);
		add_row(ils_pkg::MODE_APPEND, 7'd0, 32'h55555555, 1'b0, '0, '0, 0, 0);
		add_row(ils_pkg::MODE_APPEND, 7'd0, 32'hAAAAAAAA, 1'b0, '0, '0, 0, 0);
		add_row(ils_pkg::MODE_READ, 7'd0, 32'h0, 1'b0, '0, '0, 0, 0);
		add_row(ils_pkg::MODE_READ, 7'd5, 32'h0, 1'b0, '0, '0, 0, 0);
		add_row(ils_pkg::MODE_READ, 7'd6, 32'h0, 1'b1, NO_DATA, ils_pkg::STAT_BADIDX, 6, 10);
		add_row(ils_pkg::MODE_EDIT, 7'd2, 32'h12345678, 1'b0, '0, '0, 0, 0);
		add_row(ils_pkg::MODE_READ, 7'd2, 32'h0, 1'b0, '0, '0, 0, 0);
		add_row(ils_pkg::MODE_DELETE, 7'd0, 32'h0, 1'b0, '0, '0, 0, 0);
		add_row(ils_pkg::MODE_DELETE, 7'd4, 32'h0, 1'b0, '0, '0, 0, 0);
		add_row(ils_pkg::MODE_DELETE, 7'd7, 32'h0, 1'b1, NO_DATA, ils_pkg::STAT_BADIDX, 4, 5);
		add_row(ils_pkg::MODE_READ, 7'd64, 32'h0, 1'b1, NO_DATA, ils_pkg::STAT_BADIDX, 4, 5);
		add_row(MODE_UNUSED_MID, 7'd64, 32'h0, 1'b1, NO_DATA, ils_pkg::STAT_OK, 4, 5);
		add_row(ils_pkg::MODE_READ, 7'd3, 32'h0, 1'b0, '0, '0, 0, 0);

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (op_table[i]) begin
			send_op(op_table[i].mode, op_table[i].index, op_table[i].data,
				op_table[i].typed, op_table[i].want);
		end

		foreach (cap_settings[p]) begin
			write_capacity(cap_settings[p]);
			idle_on = (p != 2);
			if (p == 0 || p == 1) fill_and_probe();
			grow = 1'b1;
			run = $urandom_range(10, 30);
			for (int k = 0; k < 58; k++) begin
				run = run - 1;
				if (run == 0) begin
					grow = !grow;
					run = $urandom_range(10, 30);
				end
				if (p == 4 && k == 35) wait_drained();
				random_op(grow);
			end
		end

		s_axis_tvalid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (err_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
